// ----- rtl/ptc_pkg.sv -----
// Shared types and constants for the pressure/temperature compensation pipeline.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package ptc_pkg;

  // field widths
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RawW     = 24;
  localparam int unsigned TempW    = 19;
  localparam int unsigned PresW    = 25;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  // internal widths
  localparam int unsigned DtW     = 25;  // D2 - C5*2^8
  localparam int unsigned ProdW   = 42;  // dT times a 16-bit coefficient
  localparam int unsigned OffW    = 36;
  localparam int unsigned SensW   = 35;
  localparam int unsigned SensLoW = 17;  // unsigned low slice of SENS
  localparam int unsigned PpLoW   = 41;  // D1 * SENS low slice
  localparam int unsigned PpHiW   = 43;  // D1 * SENS high slice (signed)
  localparam int unsigned PresPW  = 60;  // D1 * SENS
  localparam int unsigned DiffW   = 41;  // floor(D1*SENS/2^21) - OFF

  // saturation limits
  localparam logic signed [19:0] TempMin = -20'sd140000;
  localparam logic signed [19:0] TempMax = 20'sd140000;
  localparam logic signed [19:0] TempBase = 20'sd2000;
  localparam logic signed [25:0] PresMin = -26'sd16777216;
  localparam logic signed [25:0] PresMax = 26'sd16777215;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESSURE_SENSITIVITY = 3'd0,
    REG_PRESSURE_OFFSET      = 3'd1,
    REG_SENS_TEMP_COEF       = 3'd2,
    REG_OFFSET_TEMP_COEF     = 3'd3,
    REG_REFERENCE_TEMP       = 3'd4,
    REG_TEMP_COEF            = 3'd5
  } reg_idx_e;

  typedef logic [CoefW-1:0] coef_t;

endpackage

// ----- rtl/pressure_temperature_compensation.sv -----
// Pipeline: six register stages, stage 1 through stage 6; the result of a word leaves from
// the stage-6 output register.
// Throughput: one word per cycle; stages hold only while the stage ahead is full,
// so bubbles close up under output back-pressure.
// Reset (rst_ni low, asynchronous): pipeline empties and all six coefficients clear to 0.
// Top level of the first-order barometric compensation pipeline; uses ptc_pkg.
`timescale 1ns / 1ps

module pressure_temperature_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [ptc_pkg::InDataW-1:0]   s_axis_tdata,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [18:0] temperature_centi, [43:19] pressure_centi, [47:44] zero
  output logic [ptc_pkg::OutDataW-1:0]  m_axis_tdata,
  // coefficient write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ptc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptc_pkg::CoefW-1:0]     cfg_data_i
);
  import ptc_pkg::*;

  // ---------------------------------------------------------------------------
  // Calibration coefficients C1..C6. Writes are always taken; an index past the
  // list is dropped.
  // ---------------------------------------------------------------------------
  coef_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_PRESSURE_SENSITIVITY: c1_q <= cfg_data_i;
        REG_PRESSURE_OFFSET:      c2_q <= cfg_data_i;
        REG_SENS_TEMP_COEF:       c3_q <= cfg_data_i;
        REG_OFFSET_TEMP_COEF:     c4_q <= cfg_data_i;
        REG_REFERENCE_TEMP:       c5_q <= cfg_data_i;
        REG_TEMP_COEF:            c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage flow control. Stage k loads when it is empty or its word moves on.
  // The chain runs from the output back to the slave-side ready.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || m_axis_tready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: unpack and form dT = D2 - C5*2^8 (always within 25 bits signed).
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]       d1_s1_q;
  logic signed [DtW-1:0] dt_d, dt_q;

  assign dt_d = $signed({1'b0, s_axis_tdata[2*RawW-1:RawW]})
              - $signed({1'b0, c5_q, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en1) begin
      d1_s1_q <= s_axis_tdata[RawW-1:0];
      dt_q    <= dt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the three dT products, one 25x17 multiplier each.
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]         d1_s2_q;
  logic signed [ProdW-1:0] prod_t_d, prod_o_d, prod_s_d;
  logic signed [ProdW-1:0] prod_t_q, prod_o_q, prod_s_q;

  assign prod_t_d = dt_q * $signed({1'b0, c6_q});
  assign prod_o_d = dt_q * $signed({1'b0, c4_q});
  assign prod_s_d = dt_q * $signed({1'b0, c3_q});

  always_ff @(posedge clk_i) begin
    if (en2) begin
      d1_s2_q  <= d1_s1_q;
      prod_t_q <= prod_t_d;
      prod_o_q <= prod_o_d;
      prod_s_q <= prod_s_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: TEMP (saturated), OFF and SENS. The part-selects are the floor
  // shifts by 2^23, 2^6 and 2^7.
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]          d1_s3_q;
  logic signed [19:0]       temp_sum;
  logic signed [TempW-1:0]  temp_d, temp_s3_q;
  logic signed [OffW-1:0]   off_d, off_s3_q;
  logic signed [SensW-1:0]  sens_d, sens_q;

  assign temp_sum = 20'($signed(prod_t_q[ProdW-1:23])) + TempBase;

  always_comb begin
    if (temp_sum < TempMin) begin
      temp_d = TempMin[TempW-1:0];
    end else if (temp_sum > TempMax) begin
      temp_d = TempMax[TempW-1:0];
    end else begin
      temp_d = temp_sum[TempW-1:0];
    end
  end

  assign off_d  = $signed(prod_o_q[ProdW-1:6]) + $signed({3'b000, c2_q, 17'h0_0000});
  assign sens_d = $signed(prod_s_q[ProdW-1:7]) + $signed({3'b000, c1_q, 16'h0000});

  always_ff @(posedge clk_i) begin
    if (en3) begin
      d1_s3_q   <= d1_s2_q;
      temp_s3_q <= temp_d;
      off_s3_q  <= off_d;
      sens_q    <= sens_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: D1*SENS split in two partial products around bit 17 of SENS.
  // ---------------------------------------------------------------------------
  logic signed [TempW-1:0] temp_s4_q;
  logic signed [OffW-1:0]  off_s4_q;
  logic [PpLoW-1:0]        pp_lo_d, pp_lo_q;
  logic signed [PpHiW-1:0] pp_hi_d, pp_hi_q;

  assign pp_lo_d = d1_s3_q * sens_q[SensLoW-1:0];
  assign pp_hi_d = $signed({1'b0, d1_s3_q}) * $signed(sens_q[SensW-1:SensLoW]);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      temp_s4_q <= temp_s3_q;
      off_s4_q  <= off_s3_q;
      pp_lo_q   <= pp_lo_d;
      pp_hi_q   <= pp_hi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: merge the partial products into the full 60-bit product.
  // ---------------------------------------------------------------------------
  logic signed [TempW-1:0]  temp_s5_q;
  logic signed [OffW-1:0]   off_s5_q;
  logic signed [PresPW-1:0] prod_p_d, prod_p_q;

  assign prod_p_d = $signed({pp_hi_q, 17'h0_0000}) + $signed({19'h0_0000, pp_lo_q});

  always_ff @(posedge clk_i) begin
    if (en5) begin
      temp_s5_q <= temp_s4_q;
      off_s5_q  <= off_s4_q;
      prod_p_q  <= prod_p_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: P = floor((floor(D1*SENS/2^21) - OFF) / 2^15), saturated; this is
  // the output register.
  // ---------------------------------------------------------------------------
  logic signed [DiffW-1:0] diff;
  logic signed [25:0]      pres_full;
  logic signed [PresW-1:0] pres_d, pres_q;
  logic signed [TempW-1:0] temp_q;

  assign diff      = DiffW'($signed(prod_p_q[PresPW-1:21])) - DiffW'(off_s5_q);
  assign pres_full = diff[DiffW-1:15];

  always_comb begin
    if (pres_full < PresMin) begin
      pres_d = PresMin[PresW-1:0];
    end else if (pres_full > PresMax) begin
      pres_d = PresMax[PresW-1:0];
    end else begin
      pres_d = pres_full[PresW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      temp_q <= temp_s5_q;
      pres_q <= pres_d;
    end
  end

  assign m_axis_tvalid = v6_q;
  assign m_axis_tdata  = {{(OutDataW - TempW - PresW){1'b0}}, pres_q, temp_q};

endmodule
